// ===== hw/rtl/dsq_pkg.sv =====
// Package for the delta sleep queue: transfer structs, operation and status codes,
// controller states and the command and status structs between controller and datapath.
`default_nettype none
package dsq_pkg;
  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_POP    = 2'd2,
    FUNC_TICK   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_DUP      = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  task_id;
    logic [15:0] sleep_ticks;
  } req_t;

  typedef struct packed {
    logic        popped_valid;
    logic [3:0]  popped_task;
    logic [1:0]  status;
    logic [15:0] head_ticks;
    logic [4:0]  queue_count;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESP,
    S_OUT
  } state_e;

  typedef struct packed {
    logic load;    // capture request, clear scan pointer
    logic scan;    // examine the entry at the scan pointer
    logic shift;   // move one entry and step the pointer
    logic finish;  // final write and status capture
    logic respond; // load the result register
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic shift_done;
  } stat_t;
endpackage
`default_nettype wire

// ===== hw/rtl/delta_sleep_queue_top.sv =====
// Delta sleep queue top level. Insert and remove scan and then may shift the queued entries,
// pop only shifts and tick does neither; scan and shift each step one entry per cycle.
// One request is in work at a time; the next is taken once the result is presented,
// later while a stalled result still holds the output. Reset (rst_ni low, asynchronous)
// empties the queue; slot contents stay undefined. Depends on dsq_pkg, dsq_ctrl and
// dsq_datapath.
`default_nettype none
module delta_sleep_queue_top #(
  parameter int MAX_TASKS = 16,
  parameter int TICK_BITS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire dsq_pkg::req_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output dsq_pkg::rsp_t      out_data_o
);
  dsq_pkg::cmd_t  cmd;
  dsq_pkg::stat_t stat;

  dsq_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .stat_i(stat), .cmd_o(cmd)
  );

  dsq_datapath #(.MAX_TASKS(MAX_TASKS), .TICK_BITS(TICK_BITS)) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(in_data_i),
    .cmd_i(cmd), .stat_o(stat), .rsp_o(out_data_o)
  );
endmodule
`default_nettype wire

// ===== hw/rtl/dsq_datapath.sv =====
// Datapath of the delta sleep queue: slot memories, scan pointer and response register.
// Depends on dsq_pkg; driven by dsq_ctrl through cmd_t and reports through stat_t.
`default_nettype none
module dsq_datapath #(
  parameter int MAX_TASKS = 16,
  parameter int TICK_BITS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire dsq_pkg::req_t req_i,
  input  wire dsq_pkg::cmd_t cmd_i,
  output dsq_pkg::stat_t     stat_o,
  output dsq_pkg::rsp_t      rsp_o
);
  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam logic [TICK_BITS-1:0] TMAX = '1;

  logic [3:0]           task_mem [MAX_TASKS];
  logic [TICK_BITS-1:0] delta_mem [MAX_TASKS];

  logic [CW-1:0]        count_q;
  logic [CW-1:0]        ptr_q;
  logic [CW-1:0]        pos_q;
  logic                 found_q, placed_q;
  logic [TICK_BITS:0]   run_q;
  logic [TICK_BITS-1:0] nd_q;
  logic [3:0]           head_task_q;
  dsq_pkg::req_t        req_q;
  dsq_pkg::rsp_t        rsp_q;

  logic [IW-1:0]        pi;
  logic [IW-1:0]        pn;
  logic [IW-1:0]        pp;
  logic [CW:0]          ptr_inc;
  logic [TICK_BITS:0]   sum;
  logic [TICK_BITS:0]   rsum;
  logic [TICK_BITS-1:0] req_t_w;
  logic [CW-1:0]        cnt_next;
  logic                 do_ins, do_rem, do_pop;
  logic                 shift_done;
  logic [1:0]           st_w;

  assign pi      = ptr_q[IW-1:0];
  assign pn      = IW'(ptr_q + CW'(1));
  assign pp      = IW'(ptr_q - CW'(1));
  assign ptr_inc = {1'b0, ptr_q} + (CW+1)'(1);
  assign sum     = run_q + {1'b0, delta_mem[pi]};
  assign rsum    = {1'b0, delta_mem[pn]} + {1'b0, delta_mem[pi]};
  assign req_t_w = TICK_BITS'(req_q.sleep_ticks);
  assign stat_o.scan_done = (ptr_q >= count_q) || (req_q.func == dsq_pkg::FUNC_POP)
                            || (req_q.func == dsq_pkg::FUNC_TICK);
  assign stat_o.shift_done = shift_done;
  assign rsp_o = rsp_q;

  always_comb begin
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    do_pop     = 1'b0;
    shift_done = 1'b1;
    st_w       = dsq_pkg::ST_OK;
    case (req_q.func)
      dsq_pkg::FUNC_INSERT: begin
        do_ins     = !found_q && (count_q < CW'(MAX_TASKS));
        shift_done = !do_ins || (ptr_q <= pos_q);
        if (found_q) st_w = dsq_pkg::ST_DUP;
        else if (!do_ins) st_w = dsq_pkg::ST_FULL;
      end
      dsq_pkg::FUNC_REMOVE: begin
        do_rem     = found_q;
        shift_done = !do_rem || (ptr_inc >= {1'b0, count_q});
        if (!do_rem) st_w = dsq_pkg::ST_NOTFOUND;
      end
      dsq_pkg::FUNC_POP: begin
        do_pop     = (count_q != '0);
        shift_done = !do_pop || (ptr_inc >= {1'b0, count_q});
        if (!do_pop) st_w = dsq_pkg::ST_NOTFOUND;
      end
      default: ;
    endcase
    cnt_next = count_q;
    if (do_ins) cnt_next = count_q + CW'(1);
    if (do_rem || do_pop) cnt_next = count_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
    end else if (cmd_i.load) begin
      ptr_q <= '0;
    end else if (cmd_i.scan) begin
      if (!stat_o.scan_done) ptr_q <= ptr_q + CW'(1);
      else if (req_q.func == dsq_pkg::FUNC_REMOVE) ptr_q <= pos_q;
    end else if (cmd_i.shift) begin
      if (req_q.func == dsq_pkg::FUNC_INSERT) ptr_q <= ptr_q - CW'(1);
      else ptr_q <= ptr_q + CW'(1);
    end else if (cmd_i.finish) begin
      count_q <= cnt_next;
    end
  end

  // Scan: find the task, find the insert position and its running sum.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q       <= req_i;
      head_task_q <= task_mem[0];
      found_q     <= 1'b0;
      placed_q    <= 1'b0;
      run_q       <= '0;
      pos_q       <= '0;
    end else if (cmd_i.scan) begin
      if (!stat_o.scan_done) begin
        if (task_mem[pi] == req_q.task_id && !found_q) begin
          found_q <= 1'b1;
          if (req_q.func == dsq_pkg::FUNC_REMOVE) pos_q <= ptr_q;
        end
        if (req_q.func == dsq_pkg::FUNC_INSERT && !placed_q) begin
          if (sum >= {1'b0, req_t_w}) begin
            placed_q <= 1'b1;
            pos_q    <= ptr_q;
            nd_q     <= TICK_BITS'({1'b0, req_t_w} - run_q);
          end else begin
            run_q <= sum;
            pos_q <= ptr_q + CW'(1);
          end
        end
      end else if (req_q.func == dsq_pkg::FUNC_INSERT && !placed_q) begin
        nd_q <= TICK_BITS'({1'b0, req_t_w} - run_q);
      end
    end
  end

  // Shift: insert moves entries up from the tail, remove and pop move them down.
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      if (req_q.func == dsq_pkg::FUNC_INSERT) begin
        task_mem[pi]  <= task_mem[pp];
        delta_mem[pi] <= (ptr_q == pos_q + CW'(1)) ? delta_mem[pp] - nd_q : delta_mem[pp];
      end else begin
        task_mem[pi] <= task_mem[pn];
        if (req_q.func == dsq_pkg::FUNC_REMOVE && ptr_q == pos_q) begin
          delta_mem[pi] <= rsum[TICK_BITS] ? TMAX : rsum[TICK_BITS-1:0];
        end else begin
          delta_mem[pi] <= delta_mem[pn];
        end
      end
    end else if (cmd_i.finish) begin
      if (do_ins) begin
        task_mem[pos_q[IW-1:0]]  <= req_q.task_id;
        delta_mem[pos_q[IW-1:0]] <= nd_q;
      end else if (req_q.func == dsq_pkg::FUNC_TICK && count_q != '0
                   && delta_mem[0] != '0) begin
        delta_mem[0] <= delta_mem[0] - TICK_BITS'(1);
      end
    end
  end

  logic          pv_q;
  logic [3:0]    pt_q;
  logic [1:0]    st_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      pv_q <= do_pop;
      pt_q <= do_pop ? head_task_q : 4'd0;
      st_q <= st_w;
    end
    if (cmd_i.respond) begin
      rsp_q.popped_valid <= pv_q;
      rsp_q.popped_task  <= pt_q;
      rsp_q.status       <= st_q;
      rsp_q.head_ticks   <= (count_q != '0) ? 16'(delta_mem[0]) : 16'd0;
      rsp_q.queue_count  <= 5'(count_q);
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/dsq_ctrl.sv =====
// Controller of the delta sleep queue: sequences scan, shift and finish phases.
// Depends on dsq_pkg; commands dsq_datapath and owns both handshakes.
`default_nettype none
module dsq_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  input  wire dsq_pkg::stat_t stat_i,
  output dsq_pkg::cmd_t       cmd_o
);
  dsq_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dsq_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    case (state_q)
      dsq_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = dsq_pkg::S_SCAN;
        end
      end
      dsq_pkg::S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) state_d = dsq_pkg::S_SHIFT;
      end
      dsq_pkg::S_SHIFT: begin
        if (stat_i.shift_done) state_d = dsq_pkg::S_RESP;
        else cmd_o.shift = 1'b1;
      end
      dsq_pkg::S_RESP: begin
        cmd_o.finish = 1'b1;
        state_d      = dsq_pkg::S_OUT;
      end
      dsq_pkg::S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.respond = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = dsq_pkg::S_IDLE;
        end
      end
      default: state_d = dsq_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/dsq_checker.sv =====
// Port checker for the delta sleep queue, bound to delta_sleep_queue_top.
// Depends on dsq_pkg.
`default_nettype none
module dsq_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire dsq_pkg::rsp_t out_data_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while busy");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.queue_count <= 5'd16)
    else $error("count out of range");
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.popped_valid |-> out_data_o.popped_task == 4'd0)
    else $error("popped task without pop");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.queue_count == 5'd0 |-> out_data_o.head_ticks == 16'd0)
    else $error("empty queue with head delay");
endmodule

bind delta_sleep_queue_top dsq_checker u_chk (.*);
`default_nettype wire
